>>> hw/rtl/bdac_pkg.sv
// Package: shared types and constants for the binary to decimal ASCII converter.
package bdac_pkg;

   localparam int VALUE_W    = 64;
   localparam int MODE_W     = 2;
   localparam int NUM_DIGITS = 20;
   localparam int BCD_W      = 4 * NUM_DIGITS;
   localparam int BIT_CNT_W  = $clog2(VALUE_W);
   localparam int DIG_W      = $clog2(NUM_DIGITS);
   localparam int COUNT_W    = 5;

   localparam logic [BIT_CNT_W-1:0] BIT_LAST  = BIT_CNT_W'(VALUE_W - 1);
   localparam logic [DIG_W-1:0]     DIG_FIRST = DIG_W'(NUM_DIGITS - 1);

   localparam logic [MODE_W-1:0] MODE_S32 = 2'd0;
   localparam logic [MODE_W-1:0] MODE_S64 = 2'd1;

   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_SKIP,
      ST_SIGN,
      ST_EMIT
   } state_type;

endpackage

>>> hw/rtl/binary_to_decimal_ascii_top.sv
// Top level: 64-bit binary to decimal ASCII text, bit-serial shift-add conversion.
// Sequence: one shift-add-3 conversion step per bit, then leading zero digits are skipped,
// then an optional '-' character is sent; after that, one character per cycle.
// A new item is taken only while idle; busy falls as the last character leaves.
// Reset: synchronous, clears the sequencer and the result strobe; results cannot stall.
module binary_to_decimal_ascii_top
   import bdac_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [VALUE_W-1:0]  req_value,
   input  logic [MODE_W-1:0]   req_mode,
   output logic                rsp_valid,
   output logic [7:0]          rsp_text_char,
   output logic                rsp_last_char,
   output logic [COUNT_W-1:0]  rsp_char_count
);

   state_type            state_ff, state_in;
   logic [VALUE_W-1:0]   mag_ff, mag_in;
   logic [BCD_W-1:0]     bcd_ff, bcd_in;
   logic [BIT_CNT_W-1:0] bit_cnt_ff, bit_cnt_in;
   logic [DIG_W-1:0]     dig_ff, dig_in;
   logic [COUNT_W-1:0]   cnt_ff, cnt_in;
   logic                 neg_ff, neg_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [7:0]           rsp_char_ff, rsp_char_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic [COUNT_W-1:0]   rsp_count_ff, rsp_count_in;

   logic [BCD_W-1:0]     bcd_adj;
   logic [3:0]           top_digit;
   logic [31:0]          low_word;
   logic                 take;

   assign take      = start && (state_ff == ST_IDLE);
   assign top_digit = bcd_ff[BCD_W-1 -: 4];
   assign low_word  = req_value[31:0];

   // add-3 correction on every BCD digit before the shift
   always_comb begin
      logic [3:0] d;
      for (int i = 0; i < NUM_DIGITS; i++) begin
         d = bcd_ff[4*i +: 4];
         bcd_adj[4*i +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
      end
   end

   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      bcd_in       = bcd_ff;
      bit_cnt_in   = bit_cnt_ff;
      dig_in       = dig_ff;
      cnt_in       = cnt_ff;
      neg_in       = neg_ff;
      rsp_valid_in = 1'b0;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = 1'b0;
      rsp_count_in = '0;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               bcd_in     = '0;
               bit_cnt_in = '0;
               dig_in     = DIG_FIRST;
               cnt_in     = '0;
               if (req_mode[1]) begin
                  neg_in = 1'b0;
                  mag_in = req_value;
               end else if (req_mode == MODE_S64) begin
                  neg_in = req_value[VALUE_W-1];
                  mag_in = req_value[VALUE_W-1] ? -req_value : req_value;
               end else begin
                  neg_in = low_word[31];
                  mag_in = {32'd0, (low_word[31] ? -low_word : low_word)};
               end
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            bcd_in     = {bcd_adj[BCD_W-2:0], mag_ff[VALUE_W-1]};
            mag_in     = {mag_ff[VALUE_W-2:0], 1'b0};
            bit_cnt_in = bit_cnt_ff + 1'b1;
            if (bit_cnt_ff == BIT_LAST) begin
               state_in = ST_SKIP;
            end
         end
         ST_SKIP: begin
            if (top_digit != 4'd0 || dig_ff == '0) begin
               state_in = neg_ff ? ST_SIGN : ST_EMIT;
            end else begin
               bcd_in = {bcd_ff[BCD_W-5:0], 4'd0};
               dig_in = dig_ff - 1'b1;
            end
         end
         ST_SIGN: begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = CHAR_MINUS;
            cnt_in       = COUNT_W'(1);
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            rsp_valid_in = 1'b1;
            rsp_char_in  = CHAR_ZERO + {4'd0, top_digit};
            cnt_in       = cnt_ff + 1'b1;
            bcd_in       = {bcd_ff[BCD_W-5:0], 4'd0};
            dig_in       = dig_ff - 1'b1;
            if (dig_ff == '0) begin
               rsp_last_in  = 1'b1;
               rsp_count_in = cnt_ff + 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff       <= mag_in;
      bcd_ff       <= bcd_in;
      bit_cnt_ff   <= bit_cnt_in;
      dig_ff       <= dig_in;
      cnt_ff       <= cnt_in;
      neg_ff       <= neg_in;
      rsp_char_ff  <= rsp_char_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_text_char  = rsp_char_ff;
   assign rsp_last_char  = rsp_valid_ff && rsp_last_ff;
   assign rsp_char_count = rsp_count_ff;

   // no transfer leaves while the conversion runs
   a_quiet_conv: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONV) |-> !rsp_valid_ff)
      else $error("result strobe during conversion");

   a_last_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last_char) |-> (rsp_char_count != '0))
      else $error("final character without a count");

   a_mid_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last_char) |-> (rsp_char_count == '0))
      else $error("count on a non-final character");

   a_sign_not_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_text_char == CHAR_MINUS) |-> !rsp_last_char)
      else $error("minus sign ended a number");

   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted item did not raise busy");

endmodule
